>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; every user module provides clk and rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lbgd_pkg.sv
// ----------------------------------------------------------------------------
// lbgd_pkg
// Shared types and constants of the LZSS byte-group decompressor
// ----------------------------------------------------------------------------
package lbgd_pkg;

  localparam int WINDOW_BYTES_DEF = 16384;
  localparam int COUNT_BITS_DEF   = 24;

  localparam int BYTE_W  = 8;
  localparam int OSIZE_W = 24;
  localparam int GROUP_W = 2;
  localparam int BIAS_W  = 3;
  // 12-bit distance field times a group of up to 3
  localparam int DIST_W  = 14;
  // (15 + 7) times 3 fits in 7 bits
  localparam int LEN_W   = 7;
  localparam int TOK_W   = 3;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_LEN   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GROUP_BYTES = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH_BIAS = 2'd2;

  localparam logic [OSIZE_W-1:0] FRAME_LEN_RST   = '0;
  localparam logic [GROUP_W-1:0] GROUP_BYTES_RST = 2'd1;
  localparam logic [BIAS_W-1:0]  LENGTH_BIAS_RST = 3'd1;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LIT,
    PH_LO,
    PH_HI
  } phase_t;

  typedef enum logic {
    ST_PARSE,
    ST_COPY
  } eng_state_t;

  typedef struct packed {
    logic [OSIZE_W-1:0] frame_len;
    logic [GROUP_W-1:0] group_bytes;
    logic [BIAS_W-1:0]  length_bias;
  } cfg_t;

endpackage

>>> rtl/lbgd_in_if.sv
// ----------------------------------------------------------------------------
// lbgd_in_if
// Compressed byte channel: valid/ready plus one byte and its end marker
// ----------------------------------------------------------------------------
interface lbgd_in_if;
  import lbgd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> rtl/lbgd_out_if.sv
// ----------------------------------------------------------------------------
// lbgd_out_if
// Decompressed byte channel: valid/ready plus one byte and two markers
// ----------------------------------------------------------------------------
interface lbgd_out_if;
  import lbgd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              frame_full;

  modport source (output valid, output out_byte, output run_last, output frame_full,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_full,
                  output ready);
endinterface

>>> rtl/lbgd_cfg_regs.sv
// ----------------------------------------------------------------------------
// lbgd_cfg_regs
// APB register file: output size, group size and length bias
// ----------------------------------------------------------------------------
module lbgd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbgd_pkg::PADDR_W-1:0]  paddr,
  input  logic [lbgd_pkg::PDATA_W-1:0]  pwdata,
  output logic                          pready,
  output logic [lbgd_pkg::PDATA_W-1:0]  prdata,
  output lbgd_pkg::cfg_t                cfg
);
  import lbgd_pkg::*;

  logic [OSIZE_W-1:0]   frame_len_r;
  logic [GROUP_W-1:0]   group_bytes_r;
  logic [BIAS_W-1:0]    length_bias_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r   <= FRAME_LEN_RST;
      group_bytes_r <= GROUP_BYTES_RST;
      length_bias_r <= LENGTH_BIAS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FRAME_LEN:   frame_len_r   <= pwdata[OSIZE_W-1:0];
        REG_GROUP_BYTES: group_bytes_r <= pwdata[GROUP_W-1:0];
        REG_LENGTH_BIAS: length_bias_r <= pwdata[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_FRAME_LEN:   prdata = PDATA_W'(frame_len_r);
      REG_GROUP_BYTES: prdata = PDATA_W'(group_bytes_r);
      REG_LENGTH_BIAS: prdata = PDATA_W'(length_bias_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.frame_len   = frame_len_r;
  assign cfg.group_bytes = group_bytes_r;
  assign cfg.length_bias = length_bias_r;

endmodule

>>> rtl/lbgd_hist_mem.sv
// ----------------------------------------------------------------------------
// lbgd_hist_mem
// History window: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module lbgd_hist_mem #(
  parameter int   DEPTH = lbgd_pkg::WINDOW_BYTES_DEF,
  localparam int  AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [lbgd_pkg::BYTE_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [lbgd_pkg::BYTE_W-1:0] rdata
);
  import lbgd_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lbgd_ctrl.sv
// ----------------------------------------------------------------------------
// lbgd_ctrl
// Token parser and copy engine around the history memory
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbgd_ctrl #(
  parameter int  WINDOW_BYTES = lbgd_pkg::WINDOW_BYTES_DEF,
  parameter int  COUNT_BITS   = lbgd_pkg::COUNT_BITS_DEF,
  localparam int PW           = $clog2(WINDOW_BYTES)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lbgd_pkg::cfg_t              cfg,
  lbgd_in_if.sink                     in_ch,
  lbgd_out_if.source                  out_ch,
  output logic                        mem_we,
  output logic [PW-1:0]               mem_waddr,
  output logic [lbgd_pkg::BYTE_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [PW-1:0]               mem_raddr,
  input  logic [lbgd_pkg::BYTE_W-1:0] mem_rdata
);
  import lbgd_pkg::*;

  localparam int CW    = COUNT_BITS;
  localparam int CMP_W = (CW > OSIZE_W) ? CW : OSIZE_W;
  localparam int DC_W  = (CW > DIST_W) ? CW : DIST_W;
  localparam int EW    = ((PW > DIST_W) ? PW : DIST_W) + 2;

  function automatic phase_t pick_phase(input logic [BYTE_W-1:0] flags,
                                        input logic [TOK_W-1:0] idx);
    return flags[idx] ? PH_LIT : PH_LO;
  endfunction

  // parse state
  eng_state_t          state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [BYTE_W-1:0]   flags_r, flags_nxt;
  logic [TOK_W-1:0]    tok_r, tok_nxt;
  logic [GROUP_W-1:0]  lit_r, lit_nxt;
  logic [BYTE_W-1:0]   offset_low_r, offset_low_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [PW-1:0]       wptr_r, wptr_nxt;

  // copy engine
  logic [DIST_W-1:0]   dist_r, dist_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic                last_r, last_nxt;
  logic                pend_r, pend_nxt;
  logic                fwd_r, fwd_nxt;
  logic [BYTE_W-1:0]   fwd_data_r, fwd_data_nxt;
  logic                zero_r, zero_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                run_last_r, run_last_nxt;
  logic                frame_full_r, frame_full_nxt;

  logic [GROUP_W-1:0]  grp;
  logic                can_emit, in_ready, accept, full;
  logic [CMP_W-1:0]    size_ext;
  logic [CW-1:0]       cnt_inc, cnt_cur;
  logic [PW-1:0]       wptr_inc, wptr_cur;
  logic                full_after, hit_size;
  logic [2*BYTE_W-1:0] word;
  logic [DIST_W-1:0]   dist_calc;
  logic [LEN_W-1:0]    len_calc;
  logic [TOK_W-1:0]    tok_adv;
  phase_t              phase_adv;

  logic                emit, emit_last, issue, copy_done, fwd_hit;
  logic [BYTE_W-1:0]   emit_byte;
  logic [EW-1:0]       wc_ext, dist_ext, raddr_ext;

  assign grp      = (cfg.group_bytes == '0) ? GROUP_W'(1) : cfg.group_bytes;
  assign can_emit = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == ST_PARSE) && can_emit;
  assign accept   = in_ch.valid && in_ready;
  assign size_ext = CMP_W'(cfg.frame_len);
  assign full     = CMP_W'(cnt_r) >= size_ext;

  assign cnt_inc    = (cnt_r == '1) ? cnt_r : cnt_r + CW'(1);
  assign wptr_inc   = (wptr_r == PW'(WINDOW_BYTES - 1)) ? '0 : wptr_r + PW'(1);
  assign full_after = CMP_W'(cnt_inc) >= size_ext;
  assign hit_size   = CMP_W'(cnt_inc) == size_ext;

  assign word      = {in_ch.in_byte, offset_low_r};
  assign dist_calc = DIST_W'(word[2*BYTE_W-1:4]) * DIST_W'(grp);
  assign len_calc  = LEN_W'((LEN_W'(word[3:0]) + LEN_W'(cfg.length_bias)) * LEN_W'(grp));

  assign tok_adv   = tok_r + TOK_W'(1);
  assign phase_adv = (tok_adv == '0) ? PH_FLAG : pick_phase(flags_r, tok_adv);

  // beat production and memory read issue
  always_comb begin
    emit      = 1'b0;
    emit_byte = in_ch.in_byte;
    emit_last = 1'b1;
    issue     = 1'b0;
    copy_done = 1'b0;
    if (state_r == ST_PARSE) begin
      emit = accept && !full && (phase_r == PH_LIT);
    end else if (!pend_r) begin
      issue = 1'b1;
    end else if (can_emit) begin
      emit      = 1'b1;
      emit_byte = zero_r ? '0 : (fwd_r ? fwd_data_r : mem_rdata);
      copy_done = (len_r == LEN_W'(1)) || full_after;
      emit_last = copy_done;
      issue     = !copy_done;
    end
  end

  // read address for the next copied byte, relative to its write slot
  assign wptr_cur  = emit ? wptr_inc : wptr_r;
  assign cnt_cur   = emit ? cnt_inc : cnt_r;
  assign wc_ext    = EW'(wptr_cur);
  assign dist_ext  = EW'(dist_r);
  assign raddr_ext = (wc_ext >= dist_ext) ? wc_ext - dist_ext
                                          : wc_ext + EW'(WINDOW_BYTES) - dist_ext;
  assign fwd_hit   = emit && (raddr_ext[PW-1:0] == wptr_r);

  assign mem_we    = emit;
  assign mem_waddr = wptr_r;
  assign mem_wdata = emit_byte;
  assign mem_re    = issue;
  assign mem_raddr = raddr_ext[PW-1:0];

  // engine state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_PARSE: begin
        if (accept && !full && phase_r == PH_HI && len_calc != '0) begin
          state_nxt = ST_COPY;
        end
      end
      ST_COPY: begin
        if (copy_done) begin
          state_nxt = ST_PARSE;
        end
      end
    endcase
  end

  // parser, counters and copy registers
  always_comb begin
    phase_nxt      = phase_r;
    flags_nxt      = flags_r;
    tok_nxt        = tok_r;
    lit_nxt        = lit_r;
    offset_low_nxt = offset_low_r;
    cnt_nxt        = emit ? cnt_inc : cnt_r;
    wptr_nxt       = emit ? wptr_inc : wptr_r;
    dist_nxt       = dist_r;
    len_nxt        = len_r;
    last_nxt       = last_r;
    pend_nxt       = pend_r;
    fwd_nxt        = fwd_r;
    fwd_data_nxt   = fwd_data_r;
    zero_nxt       = zero_r;

    if (accept) begin
      if (!full) begin
        unique case (phase_r)
          PH_FLAG: begin
            flags_nxt = in_ch.in_byte;
            tok_nxt   = '0;
            phase_nxt = pick_phase(in_ch.in_byte, '0);
            lit_nxt   = grp;
          end
          PH_LIT: begin
            lit_nxt = lit_r - GROUP_W'(1);
            if (lit_r == GROUP_W'(1)) begin
              tok_nxt   = tok_adv;
              phase_nxt = phase_adv;
              lit_nxt   = grp;
            end
          end
          PH_LO: begin
            offset_low_nxt = in_ch.in_byte;
            phase_nxt      = PH_HI;
          end
          PH_HI: begin
            tok_nxt   = tok_adv;
            phase_nxt = phase_adv;
            lit_nxt   = grp;
            dist_nxt  = dist_calc;
            len_nxt   = len_calc;
            last_nxt  = in_ch.in_last;
            pend_nxt  = 1'b0;
          end
        endcase
      end
      if (in_ch.in_last) begin
        phase_nxt      = PH_FLAG;
        flags_nxt      = '0;
        tok_nxt        = '0;
        lit_nxt        = '0;
        offset_low_nxt = '0;
        // a pending copy still needs the stream position
        if (state_nxt == ST_PARSE) begin
          cnt_nxt  = '0;
          wptr_nxt = '0;
        end
      end
    end

    if (state_r == ST_COPY) begin
      if (emit) begin
        len_nxt = len_r - LEN_W'(1);
      end
      if (copy_done) begin
        pend_nxt = 1'b0;
        if (last_r) begin
          cnt_nxt  = '0;
          wptr_nxt = '0;
        end
      end
      if (issue) begin
        pend_nxt     = 1'b1;
        fwd_nxt      = fwd_hit;
        fwd_data_nxt = emit_byte;
        zero_nxt     = (dist_r == '0) || (DC_W'(dist_r) > DC_W'(cnt_cur)) ||
                       (32'(dist_r) > 32'(WINDOW_BYTES));
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    run_last_nxt   = run_last_r;
    frame_full_nxt = frame_full_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = emit_byte;
      run_last_nxt   = emit_last;
      frame_full_nxt = hit_size;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_PARSE;
      phase_r      <= PH_FLAG;
      flags_r      <= '0;
      tok_r        <= '0;
      lit_r        <= '0;
      offset_low_r <= '0;
      cnt_r        <= '0;
      wptr_r       <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      flags_r      <= flags_nxt;
      tok_r        <= tok_nxt;
      lit_r        <= lit_nxt;
      offset_low_r <= offset_low_nxt;
      cnt_r        <= cnt_nxt;
      wptr_r       <= wptr_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r       <= dist_nxt;
    len_r        <= len_nxt;
    last_r       <= last_nxt;
    fwd_r        <= fwd_nxt;
    fwd_data_r   <= fwd_data_nxt;
    zero_r       <= zero_nxt;
    out_byte_r   <= out_byte_nxt;
    run_last_r   <= run_last_nxt;
    frame_full_r <= frame_full_nxt;
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.run_last   = run_last_r;
  assign out_ch.frame_full = frame_full_r;

  `ASSERT_IMPL(a_copy_blocks_input, state_r == ST_COPY, !in_ready, "input taken during copy")
  `ASSERT_IMPL(a_copy_len_nonzero, state_r == ST_COPY, len_r != '0, "copy with no bytes left")
  `ASSERT_IMPL(a_fwd_only_dist_one, issue && fwd_hit, dist_r == DIST_W'(1), "bad forward")
  `ASSERT_NEXT(a_full_ends_copy, emit && full_after, state_r == ST_PARSE, "copy ran past size")

endmodule

>>> rtl/lzss_byte_group_decompressor_top.sv
// ----------------------------------------------------------------------------
// lzss_byte_group_decompressor_top
// LZSS decompressor with byte-group scaling and a synchronous history window
// ----------------------------------------------------------------------------
//   port      dir   kind            payload
//   in_ch     in    valid/ready     in_byte[7:0], in_last
//   out_ch    out   valid/ready     out_byte[7:0], run_last, frame_full
//   psel..    in    apb, 32-bit     frame_len @0x0, group_bytes @0x4, length_bias @0x8
//
// flag, literal and low offset bytes are each consumed in a single input handshake.
// a match byte is decoded, then the history read is primed, then the copy gives one
// output beat per cycle through the single read port of the history memory.
// a stalled output holds the copy; the next input waits until the copy is done.
// synchronous active-low reset; the history memory is not cleared.
// ----------------------------------------------------------------------------
module lzss_byte_group_decompressor_top #(
  parameter int WINDOW_BYTES = lbgd_pkg::WINDOW_BYTES_DEF,
  parameter int COUNT_BITS   = lbgd_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lbgd_in_if.sink                       in_ch,
  lbgd_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbgd_pkg::PADDR_W-1:0]  paddr,
  input  logic [lbgd_pkg::PDATA_W-1:0]  pwdata,
  output logic                          pready,
  output logic [lbgd_pkg::PDATA_W-1:0]  prdata
);
  import lbgd_pkg::*;

  localparam int PW = $clog2(WINDOW_BYTES);

  cfg_t              cfg;
  logic              mem_we;
  logic [PW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [PW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  lbgd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  lbgd_hist_mem #(
    .DEPTH (WINDOW_BYTES)
  ) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lbgd_ctrl #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .COUNT_BITS   (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule
